// File: hdl/lwbc_pkg.sv
// Package for the write-back cache timing unit: commands, register indexes,
// controller states and the layout of one stored way.
// No dependencies.
`default_nettype none

package lwbc_pkg;

   // input commands
   localparam logic [1:0] CMD_READ  = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_FLUSH = 2'd2;

   // configuration register indexes
   localparam logic [2:0] REG_BYTES_PER_WORD  = 3'd0;
   localparam logic [2:0] REG_WORDS_PER_BLOCK = 3'd1;
   localparam logic [2:0] REG_SETS_IN_USE     = 3'd2;
   localparam logic [2:0] REG_WAYS_IN_USE     = 3'd3;
   localparam logic [2:0] REG_HIT_TIME        = 3'd4;
   localparam logic [2:0] REG_READ_TIME       = 3'd5;
   localparam logic [2:0] REG_WRITE_TIME      = 3'd6;

   localparam logic [23:0] TIME_MAX = 24'hFF_FFFF;
   localparam int unsigned DIV_STEPS = 32;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV_BLK,
      ST_DIV_SET,
      ST_READ,
      ST_EVAL,
      ST_FLUSH_RD,
      ST_FLUSH_WR,
      ST_RESP
   } state_type;

   // one way of a set as held in the tag memory
   typedef struct packed {
      logic [31:0] tag;
      logic        valid;
      logic        dirty;
      logic [7:0]  rec;
   } way_type;

endpackage

`default_nettype wire

// File: hdl/lru_writeback_cache_timing_unit.sv
// Top level of the write-back LRU cache timing unit: config registers,
// shared serial divider, tag memory and the read-modify-write controller.
// Depends on lwbc_pkg.
//
//   port group | direction | contents
//   req_*      | in        | command, byte address (valid / stall)
//   rsp_*      | out       | set index, hit, access time (valid / stall)
//   csr_*      | in        | write enable, register index, write data
//
// A read or write runs 32 divider steps for the block address, 32 for the
// set, then one memory read and one evaluate/write step.
// A flush reads and writes back every row of the tag memory in turn.
// After reset a clearing pass zeroes every row of the tag memory; no item
// is taken meanwhile. A stalled result is held in the output register and
// the next item is taken; that item waits at its end until the output frees.
`default_nettype none

module lru_writeback_cache_timing_unit
   import lwbc_pkg::*;
#(
   parameter int MAX_SETS = 256,
   parameter int MAX_WAYS = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_command,
   input  wire logic [31:0] req_address,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_set_index,
   output logic             rsp_hit,
   output logic [23:0]      rsp_access_time,
   input  wire logic        csr_write_enable,
   input  wire logic [2:0]  csr_index,
   input  wire logic [9:0]  csr_write_data
);

   localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
   localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int CNT_W = $clog2(MAX_WAYS + 1);
   localparam logic [SET_W-1:0] LAST_ROW = SET_W'(MAX_SETS - 1);

   typedef way_type [MAX_WAYS-1:0] row_type;

   // configuration registers, raw values
   logic [4:0] bpw_ff;
   logic [6:0] wpb_ff;
   logic [8:0] sets_ff;
   logic [3:0] ways_ff;
   logic [9:0] hit_time_ff, read_time_ff, write_time_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bpw_ff        <= 5'd4;
         wpb_ff        <= 7'd1;
         sets_ff       <= 9'd1;
         ways_ff       <= 4'd1;
         hit_time_ff   <= 10'd1;
         read_time_ff  <= 10'd10;
         write_time_ff <= 10'd10;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_BYTES_PER_WORD:  bpw_ff        <= csr_write_data[4:0];
            REG_WORDS_PER_BLOCK: wpb_ff        <= csr_write_data[6:0];
            REG_SETS_IN_USE:     sets_ff       <= csr_write_data[8:0];
            REG_WAYS_IN_USE:     ways_ff       <= csr_write_data[3:0];
            REG_HIT_TIME:        hit_time_ff   <= csr_write_data;
            REG_READ_TIME:       read_time_ff  <= csr_write_data;
            REG_WRITE_TIME:      write_time_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // registers clamped into their ranges
   logic [4:0]  bpw_eff;
   logic [6:0]  wpb_eff;
   logic [8:0]  sets_c, sets_eff;
   logic [3:0]  ways_c, ways_eff;
   logic [10:0] blk_div;

   always_comb begin
      bpw_eff  = (bpw_ff == 5'd0) ? 5'd1 : ((bpw_ff > 5'd16) ? 5'd16 : bpw_ff);
      wpb_eff  = (wpb_ff == 7'd0) ? 7'd1 : ((wpb_ff > 7'd64) ? 7'd64 : wpb_ff);
      sets_c   = (sets_ff == 9'd0) ? 9'd1 : ((sets_ff > 9'd256) ? 9'd256 : sets_ff);
      sets_eff = (32'(sets_c) > 32'(MAX_SETS)) ? 9'(MAX_SETS) : sets_c;
      ways_c   = (ways_ff == 4'd0) ? 4'd1 : ((ways_ff > 4'd8) ? 4'd8 : ways_ff);
      ways_eff = (32'(ways_c) > 32'(MAX_WAYS)) ? 4'(MAX_WAYS) : ways_c;
      blk_div  = 11'(bpw_eff) * 11'(wpb_eff);
   end

   // controller and datapath registers
   state_type        state_ff, state_in;
   logic [1:0]       cmd_ff, cmd_in;
   logic [31:0]      num_ff, num_in;
   logic [10:0]      rem_ff, rem_in;
   logic [10:0]      div_ff, div_in;
   logic [4:0]       step_ff, step_in;
   logic [31:0]      baddr_ff, baddr_in;
   logic [SET_W-1:0] row_ff, row_in;
   logic [7:0]       res_set_ff, res_set_in;
   logic             res_hit_ff, res_hit_in;
   logic [23:0]      res_time_ff, res_time_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_set_ff, rsp_set_in;
   logic             rsp_hit_ff, rsp_hit_in;
   logic [23:0]      rsp_time_ff, rsp_time_in;

   // tag memory, one row per set
   row_type          row_mem [MAX_SETS];
   row_type          rd_row_ff;
   row_type          mem_wdata;
   logic             mem_we, mem_re;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         row_mem[row_ff] <= mem_wdata;
      end
      if (mem_re) begin
         rd_row_ff <= row_mem[row_ff];
      end
   end

   // restoring divider step, one quotient bit per cycle
   logic [11:0] trial;
   logic        ge;
   logic [10:0] rem_next;
   logic [31:0] num_next;
   logic        last_step, last_row;

   always_comb begin
      trial     = {rem_ff, num_ff[31]};
      ge        = trial >= {1'b0, div_ff};
      rem_next  = ge ? 11'(trial - {1'b0, div_ff}) : trial[10:0];
      num_next  = {num_ff[30:0], ge};
      last_step = step_ff == 5'(DIV_STEPS - 1);
      last_row  = row_ff == LAST_ROW;
   end

   // lookup and replacement over the ways of the set
   logic [MAX_WAYS-1:0] inuse, vw, match;
   logic                hit, full, vfound, ffound, is_write, evict_dirty;
   logic [WAY_W-1:0]    hit_way, victim, free_way, slot;
   logic [7:0]          best, hit_rec;
   logic [11:0]         acc_time;
   row_type             upd_row;

   always_comb begin
      hit      = 1'b0;
      hit_way  = '0;
      vfound   = 1'b0;
      victim   = '0;
      best     = '0;
      ffound   = 1'b0;
      free_way = '0;
      full     = 1'b1;
      is_write = cmd_ff == CMD_WRITE;
      for (int w = 0; w < MAX_WAYS; w++) begin
         inuse[w] = 32'(w) < 32'(ways_eff);
         vw[w]    = inuse[w] && rd_row_ff[w].valid;
         match[w] = vw[w] && (rd_row_ff[w].tag == baddr_ff);
         if (inuse[w] && !rd_row_ff[w].valid) begin
            full = 1'b0;
         end
      end
      for (int w = 0; w < MAX_WAYS; w++) begin
         if (match[w] && !hit) begin
            hit     = 1'b1;
            hit_way = WAY_W'(w);
         end
         if (vw[w] && (!vfound || rd_row_ff[w].rec > best)) begin
            vfound = 1'b1;
            victim = WAY_W'(w);
            best   = rd_row_ff[w].rec;
         end
         if (inuse[w] && !rd_row_ff[w].valid && !ffound) begin
            ffound   = 1'b1;
            free_way = WAY_W'(w);
         end
      end
      slot        = full ? victim : free_way;
      hit_rec     = rd_row_ff[hit_way].rec;
      evict_dirty = !hit && full && rd_row_ff[victim].dirty;

      upd_row = rd_row_ff;
      if (hit) begin
         for (int w = 0; w < MAX_WAYS; w++) begin
            if (vw[w] && rd_row_ff[w].rec < hit_rec) begin
               upd_row[w].rec = rd_row_ff[w].rec + 8'd1;
            end
         end
         upd_row[hit_way].rec = 8'd0;
         if (is_write) begin
            upd_row[hit_way].dirty = 1'b1;
         end
      end else begin
         for (int w = 0; w < MAX_WAYS; w++) begin
            if (vw[w] && rd_row_ff[w].rec != 8'hFF) begin
               upd_row[w].rec = rd_row_ff[w].rec + 8'd1;
            end
         end
         upd_row[slot].tag   = baddr_ff;
         upd_row[slot].valid = 1'b1;
         upd_row[slot].dirty = is_write;
         upd_row[slot].rec   = 8'd0;
      end

      // at most three 10-bit terms, never near the 24-bit ceiling
      acc_time = {2'b00, hit_time_ff};
      if (evict_dirty) begin
         acc_time = acc_time + {2'b00, write_time_ff};
      end
      if (!hit && !(is_write && wpb_eff == 7'd1)) begin
         acc_time = acc_time + {2'b00, read_time_ff};
      end
   end

   // flush: clean one row and charge its dirty blocks
   row_type          cln_row;
   logic [CNT_W-1:0] dcount;
   logic [24:0]      fl_sum;

   always_comb begin
      cln_row = rd_row_ff;
      dcount  = '0;
      for (int w = 0; w < MAX_WAYS; w++) begin
         if (rd_row_ff[w].valid && rd_row_ff[w].dirty) begin
            cln_row[w].dirty = 1'b0;
            dcount           = dcount + CNT_W'(1);
         end
      end
      fl_sum = {1'b0, res_time_ff} + 25'(dcount) * 25'(write_time_ff);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:    if (last_row) state_in = ST_IDLE;
         ST_IDLE: begin
            if (req_valid) begin
               case (req_command)
                  CMD_READ, CMD_WRITE: state_in = ST_DIV_BLK;
                  CMD_FLUSH:           state_in = ST_FLUSH_RD;
                  default:             state_in = ST_RESP;
               endcase
            end
         end
         ST_DIV_BLK:  if (last_step) state_in = ST_DIV_SET;
         ST_DIV_SET:  if (last_step) state_in = ST_READ;
         ST_READ:     state_in = ST_EVAL;
         ST_EVAL:     state_in = ST_RESP;
         ST_FLUSH_RD: state_in = ST_FLUSH_WR;
         ST_FLUSH_WR: state_in = last_row ? ST_RESP : ST_FLUSH_RD;
         ST_RESP:     if (!rsp_valid_ff || !rsp_stall) state_in = ST_IDLE;
         default:     state_in = ST_CLEAR;
      endcase
   end

   // outputs and datapath updates
   always_comb begin
      req_stall    = state_ff != ST_IDLE;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_wdata    = '0;
      cmd_in       = cmd_ff;
      num_in       = num_ff;
      rem_in       = rem_ff;
      div_in       = div_ff;
      step_in      = step_ff;
      baddr_in     = baddr_ff;
      row_in       = row_ff;
      res_set_in   = res_set_ff;
      res_hit_in   = res_hit_ff;
      res_time_in  = res_time_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_set_in   = rsp_set_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_time_in  = rsp_time_ff;
      case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            row_in = row_ff + SET_W'(1);
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in      = req_command;
               num_in      = req_address;
               rem_in      = '0;
               div_in      = blk_div;
               step_in     = '0;
               row_in      = '0;
               res_set_in  = '0;
               res_hit_in  = 1'b0;
               res_time_in = '0;
            end
         end
         ST_DIV_BLK: begin
            num_in  = num_next;
            rem_in  = rem_next;
            step_in = step_ff + 5'd1;
            if (last_step) begin
               baddr_in = num_next;
               rem_in   = '0;
               div_in   = 11'(sets_eff);
            end
         end
         ST_DIV_SET: begin
            num_in  = num_next;
            rem_in  = rem_next;
            step_in = step_ff + 5'd1;
            if (last_step) begin
               row_in     = SET_W'(rem_next);
               res_set_in = rem_next[7:0];
            end
         end
         ST_READ:     mem_re = 1'b1;
         ST_EVAL: begin
            mem_we      = 1'b1;
            mem_wdata   = upd_row;
            res_hit_in  = hit;
            res_time_in = 24'(acc_time);
         end
         ST_FLUSH_RD: mem_re = 1'b1;
         ST_FLUSH_WR: begin
            mem_we      = 1'b1;
            mem_wdata   = cln_row;
            row_in      = row_ff + SET_W'(1);
            res_time_in = (fl_sum > {1'b0, TIME_MAX}) ? TIME_MAX : fl_sum[23:0];
         end
         ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_set_in   = res_set_ff;
               rsp_hit_in   = res_hit_ff;
               rsp_time_in  = res_time_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      num_ff      <= num_in;
      rem_ff      <= rem_in;
      div_ff      <= div_in;
      step_ff     <= step_in;
      baddr_ff    <= baddr_in;
      res_set_ff  <= res_set_in;
      res_hit_ff  <= res_hit_in;
      res_time_ff <= res_time_in;
      rsp_set_ff  <= rsp_set_in;
      rsp_hit_ff  <= rsp_hit_in;
      rsp_time_ff <= rsp_time_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_set_index   = rsp_set_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_access_time = rsp_time_ff;

   // checks
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> req_stall)
      else $error("item taken during tag clear");

   a_eval_after_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EVAL |-> $past(state_ff) == ST_READ)
      else $error("evaluate without a memory read");

   a_set_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |-> 32'(row_ff) < 32'(sets_eff))
      else $error("set index beyond sets in use");

   a_slot_in_use: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EVAL && !hit |-> inuse[slot])
      else $error("miss fills a way outside the ways in use");

endmodule

`default_nettype wire

// File: bench/tb.sv
// Self-checking bench for the write-back LRU cache timing unit: drives read,
// write, flush and unused commands over several register settings and checks
// every result against a given value or a model of tags, dirty bits, recency.
// Depends on lwbc_pkg and lru_writeback_cache_timing_unit.
`timescale 1ns / 1ps

module tb;
   import lwbc_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int NUM_SETS = 256;
   localparam int NUM_WAYS = 8;
   localparam int NUM_SLOTS = NUM_SETS * NUM_WAYS;
   localparam int PHASES = 8;
   localparam int PHASE_ITEMS = 225;
   localparam int CYCLE_LIMIT = 3000000;

   typedef struct packed {
      logic [7:0]  set_index;
      logic        hit;
      logic [23:0] access_time;
   } cache_result_type;

   typedef struct {
      logic [1:0]       command;
      logic [31:0]      address;
      bit               known;
      cache_result_type result;
   } access_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_command;
   logic [31:0] req_address;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_set_index;
   logic        rsp_hit;
   logic [23:0] rsp_access_time;
   logic        csr_write_enable;
   logic [2:0]  csr_index;
   logic [9:0]  csr_write_data;

   // model state: one slot per way of each set
   logic [31:0] slot_tag[NUM_SLOTS];
   bit          slot_valid[NUM_SLOTS];
   bit          slot_dirty[NUM_SLOTS];
   bit [7:0]    slot_rec[NUM_SLOTS];
   logic [9:0]  cfg_reg[7];

   cache_result_type pending_results[$];
   int error_count = 0;
   int cycle_count = 0;
   bit idling_on = 1;

   lru_writeback_cache_timing_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_command(req_command), .req_address(req_address),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_set_index(rsp_set_index), .rsp_hit(rsp_hit),
      .rsp_access_time(rsp_access_time),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   // watchdog
   initial begin
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   function automatic int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic int unsigned sat_time(int unsigned a, int unsigned b);
      longint unsigned s;
      s = longint'(a) + longint'(b);
      return (s > 64'hFF_FFFF) ? 32'hFF_FFFF : int'(s);
   endfunction

   // predicts one access and updates tags, dirty bits and recency
   function automatic cache_result_type cache_access(logic [1:0] cmd, logic [31:0] addr);
      int unsigned bpw, wpb, sets, ways, baddr, set_no, base, slot, count, hit_way, t;
      bit hit_found, is_write;
      bit [7:0] r, oldest;
      cache_result_type res;
      res = '0;
      bpw = clamp(cfg_reg[REG_BYTES_PER_WORD][4:0], 1, 16);
      wpb = clamp(cfg_reg[REG_WORDS_PER_BLOCK][6:0], 1, 64);
      sets = clamp(cfg_reg[REG_SETS_IN_USE][8:0], 1, NUM_SETS);
      ways = clamp(cfg_reg[REG_WAYS_IN_USE][3:0], 1, NUM_WAYS);
      is_write = (cmd == CMD_WRITE);
      hit_found = 0;
      hit_way = 0;
      count = 0;
      t = 0;
      if (cmd == CMD_UNUSED) return res;
      // flush cleans every dirty entry, including ways now out of use
      if (cmd == CMD_FLUSH) begin
         for (int i = 0; i < NUM_SLOTS; i++)
            if (slot_valid[i] && slot_dirty[i]) begin
               t = sat_time(t, cfg_reg[REG_WRITE_TIME]);
               slot_dirty[i] = 0;
            end
         res.access_time = t[23:0];
         return res;
      end
      t = cfg_reg[REG_HIT_TIME];
      baddr = addr / (bpw * wpb);
      set_no = baddr % sets;
      base = set_no * NUM_WAYS;
      for (int w = 0; w < ways; w++)
         if (slot_valid[base + w]) begin
            count++;
            if (!hit_found && slot_tag[base + w] == baddr) begin
               hit_found = 1;
               hit_way = w;
            end
         end
      if (hit_found) begin
         r = slot_rec[base + hit_way];
         if (is_write) slot_dirty[base + hit_way] = 1;
         for (int w = 0; w < ways; w++)
            if (slot_valid[base + w] && slot_rec[base + w] < r) slot_rec[base + w]++;
         slot_rec[base + hit_way] = 0;
      end else begin
         slot = ways;
         if (count >= ways) begin
            // evict the oldest valid way, lowest way on a tie
            oldest = 0;
            for (int w = 0; w < ways; w++)
               if (slot_valid[base + w] && (slot == ways || slot_rec[base + w] > oldest)) begin
                  slot = w;
                  oldest = slot_rec[base + w];
               end
            if (slot_dirty[base + slot]) t = sat_time(t, cfg_reg[REG_WRITE_TIME]);
            slot_valid[base + slot] = 0;
            slot_dirty[base + slot] = 0;
         end else begin
            for (int w = 0; w < ways; w++)
               if (!slot_valid[base + w] && slot == ways) slot = w;
         end
         // a one-word block needs no fetch on a write
         if (!(is_write && wpb == 1)) t = sat_time(t, cfg_reg[REG_READ_TIME]);
         for (int w = 0; w < ways; w++)
            if (slot_valid[base + w] && slot_rec[base + w] < 255) slot_rec[base + w]++;
         if (slot < ways) begin
            slot_tag[base + slot] = baddr;
            slot_valid[base + slot] = 1;
            slot_dirty[base + slot] = is_write;
            slot_rec[base + slot] = 0;
         end
      end
      res.set_index = set_no[7:0];
      res.hit = hit_found;
      res.access_time = t[23:0];
      return res;
   endfunction

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
      error_count++;
   endtask

   // result side: check and random stall bursts
   initial begin
      int stall_left;
      cache_result_type want;
      stall_left = 0;
      rsp_stall <= 0;
      forever begin
         @(posedge clock);
         if (rsp_valid === 1'b1 && rsp_stall == 0) begin
            if (pending_results.size() == 0) begin
               $display("unexpected result at cycle %0d", cycle_count);
               error_count++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_set_index !== want.set_index)
                  report("set_index", 32'(rsp_set_index), 32'(want.set_index));
               if (rsp_hit !== want.hit) report("hit", 32'(rsp_hit), 32'(want.hit));
               if (rsp_access_time !== want.access_time)
                  report("access_time", 32'(rsp_access_time), 32'(want.access_time));
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1;
         end else if (idling_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 10);
            rsp_stall <= 1;
         end else begin
            rsp_stall <= 0;
         end
      end
   end

   task automatic write_reg(logic [2:0] idx, logic [9:0] data);
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      cfg_reg[idx] = data;
   endtask

   task automatic wait_drained();
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // sends one item and records its expected result on acceptance
   task automatic send_item(logic [1:0] cmd, logic [31:0] addr, bit known,
                            cache_result_type typed);
      cache_result_type predicted;
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid <= 1;
      req_command <= cmd;
      req_address <= addr;
      do @(posedge clock); while (req_stall !== 1'b0);
      predicted = cache_access(cmd, addr);
      pending_results.push_back(known ? typed : predicted);
   endtask

   // register settings per random phase; out-of-range values included
   logic [9:0] phase_cfg[PHASES][7] = '{
      '{10'd16, 10'd64, 10'd256, 10'd8, 10'd1023, 10'd1023, 10'd1023},
      '{10'd1,  10'd1,  10'd1,   10'd1, 10'd0,    10'd0,    10'd0},
      '{10'd0,  10'd0,  10'd0,   10'd0, 10'd5,    10'd7,    10'd3},
      '{10'd31, 10'd127, 10'd511, 10'd15, 10'd1023, 10'd0,  10'd1023},
      '{10'd4,  10'd1,  10'd4,   10'd8, 10'd2,    10'd20,   10'd30},
      '{10'd8,  10'd4,  10'd16,  10'd3, 10'd1,    10'd100,  10'd50},
      '{10'd2,  10'd8,  10'd8,   10'd4, 10'd0,    10'd0,    10'd0},
      '{10'd4,  10'd2,  10'd32,  10'd8, 10'd3,    10'd11,   10'd13}
   };

   // directed accesses under the reset settings (one set, one way, 4-byte words)
   access_row_type directed[] = '{
      '{CMD_READ,  32'h0000_0000, 1, '{8'd0, 1'b0, 24'd11}},
      '{CMD_READ,  32'h0000_0003, 1, '{8'd0, 1'b1, 24'd1}},
      '{CMD_WRITE, 32'h0000_0000, 1, '{8'd0, 1'b1, 24'd1}},
      '{CMD_READ,  32'h0000_0004, 1, '{8'd0, 1'b0, 24'd21}},
      '{CMD_WRITE, 32'h0000_0008, 1, '{8'd0, 1'b0, 24'd1}},
      '{CMD_FLUSH, 32'hFFFF_FFFF, 1, '{8'd0, 1'b0, 24'd10}},
      '{CMD_FLUSH, 32'h0000_0000, 1, '{8'd0, 1'b0, 24'd0}},
      '{CMD_UNUSED, 32'hFFFF_FFFF, 1, '{8'd0, 1'b0, 24'd0}},
      '{CMD_READ,  32'hFFFF_FFFF, 1, '{8'd0, 1'b0, 24'd11}},
      '{CMD_WRITE, 32'hFFFF_FFFC, 1, '{8'd0, 1'b1, 24'd1}},
      '{CMD_WRITE, 32'h5555_5555, 0, '0},
      '{CMD_READ,  32'hAAAA_AAAA, 0, '0},
      '{CMD_FLUSH, 32'h0000_0000, 0, '0},
      '{CMD_READ,  32'h5555_5554, 0, '0}
   };

   initial begin
      int unsigned span, bsize;
      logic [1:0] cmd;
      logic [31:0] addr;
      int pick;
      reset <= 1;
      req_valid <= 0;
      req_command <= CMD_READ;
      req_address <= '0;
      csr_write_enable <= 0;
      csr_index <= REG_BYTES_PER_WORD;
      csr_write_data <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         slot_tag[i] = '0;
         slot_valid[i] = 0;
         slot_dirty[i] = 0;
         slot_rec[i] = 0;
      end
      cfg_reg = '{10'd4, 10'd1, 10'd1, 10'd1, 10'd1, 10'd10, 10'd10};
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed part
      foreach (directed[i])
         send_item(directed[i].command, directed[i].address, directed[i].known,
                   directed[i].result);
      req_valid <= 0;

      // random phases, one register setting each
      for (int p = 0; p < PHASES; p++) begin
         wait_drained();
         repeat (600) @(posedge clock);
         for (int r = 0; r < 7; r++) write_reg(r[2:0], phase_cfg[p][r]);
         csr_write_enable <= 0;
         idling_on = (p != 0 && p < PHASES - 1);
         bsize = clamp(cfg_reg[REG_BYTES_PER_WORD][4:0], 1, 16)
               * clamp(cfg_reg[REG_WORDS_PER_BLOCK][6:0], 1, 64);
         span = bsize * clamp(cfg_reg[REG_SETS_IN_USE][8:0], 1, NUM_SETS)
              * clamp(cfg_reg[REG_WAYS_IN_USE][3:0], 1, NUM_WAYS) * 2;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // hold off once until the unit has drained
            if (p == 3 && n == PHASE_ITEMS / 2) begin
               req_valid <= 0;
               wait_drained();
            end
            pick = $urandom_range(0, 99);
            if (pick < 3) cmd = CMD_FLUSH;
            else if (pick < 5) cmd = CMD_UNUSED;
            else cmd = $urandom_range(0, 1) ? CMD_WRITE : CMD_READ;
            if ($urandom_range(0, 9) == 0) addr = $urandom;
            else addr = $urandom_range(0, span - 1);
            send_item(cmd, addr, 0, '0);
         end
         req_valid <= 0;
      end

      wait_drained();
      repeat (600) @(posedge clock);
      if (error_count == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

endmodule

// File: filelist.f
hdl/lwbc_pkg.sv
hdl/lru_writeback_cache_timing_unit.sv
bench/tb.sv
